/* hw/rtl/cksn_pkg.sv */
// Shared types, constants and the CRC-16/XMODEM byte update for the key slot block.
// No dependencies; every other file of the block imports this package.
package cksn_pkg;

   localparam int KEY_BYTE_WIDTH = 8;
   localparam int CRC_WIDTH      = 16;
   localparam int SLOT_WIDTH     = 14;
   localparam int NODE_WIDTH     = 3;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int NUM_STARTS     = 5;

   localparam logic [CRC_WIDTH-1:0]      CRC_POLY    = 16'h1021;
   localparam logic [KEY_BYTE_WIDTH-1:0] OPEN_BRACE  = 8'h7B;
   localparam logic [KEY_BYTE_WIDTH-1:0] CLOSE_BRACE = 8'h7D;
   localparam logic [NODE_WIDTH-1:0]     NODE_FIRST  = 3'd1;
   localparam logic [NODE_WIDTH-1:0]     NODE_OF_START_BASE = 3'd2;

   typedef logic [SLOT_WIDTH-1:0] slot_type;
   typedef logic [NODE_WIDTH-1:0] node_type;
   typedef logic [CRC_WIDTH-1:0]  crc_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_NODE2_START = 3'd0,
      CSR_NODE3_START = 3'd1,
      CSR_NODE4_START = 3'd2,
      CSR_NODE5_START = 3'd3,
      CSR_NODE6_START = 3'd4
   } csr_index_type;

   localparam slot_type START_RESET [NUM_STARTS] = '{
      14'd2731, 14'd5461, 14'd8192, 14'd10923, 14'd13653
   };

   // Finished key handed from the hash stage to the node lookup stage.
   typedef struct packed {
      logic     valid;
      logic     empty;
      slot_type slot;
   } slot_stage_type;

   function automatic crc_type crc16_byte(crc_type crc, logic [KEY_BYTE_WIDTH-1:0] b);
      crc_type c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[CRC_WIDTH-1]) begin
            c = {c[CRC_WIDTH-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_WIDTH-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hw/rtl/cksn_if.sv */
// Handshake interfaces for the key byte, result and register write channels.
// Depends on cksn_pkg for payload widths.
interface cksn_req_if import cksn_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KEY_BYTE_WIDTH-1:0] key_byte;
   logic                      last_byte;
   logic                      empty_key;
   modport source (output valid, key_byte, last_byte, empty_key, input ready);
   modport sink   (input valid, key_byte, last_byte, empty_key, output ready);
endinterface

interface cksn_rsp_if import cksn_pkg::*; ();
   logic     valid;
   logic     ready;
   slot_type slot;
   node_type node;
   modport source (output valid, slot, node, input ready);
   modport sink   (input valid, slot, node, output ready);
endinterface

interface cksn_csr_if import cksn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_WIDTH-1:0] index;
   slot_type                 data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/cksn_key_hash.sv */
// Per-key CRC state and brace tracking; registers the slot when a key ends.
// Depends on cksn_pkg and cksn_req_if.
module cksn_key_hash import cksn_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   cksn_req_if.sink       req,
   input  logic           stage_ready,
   output slot_stage_type stage
);

   crc_type        crc_whole_ff, crc_whole_in;
   crc_type        crc_tag_ff, crc_tag_in;
   logic           open_seen_ff, open_seen_in;
   logic           close_seen_ff, close_seen_in;
   logic           tag_nonempty_ff, tag_nonempty_in;
   slot_stage_type stage_ff, stage_in;

   logic    accept;
   logic    key_done;
   crc_type crc_pick;

   assign req.ready = !stage_ff.valid || stage_ready;
   assign accept    = req.valid && req.ready;
   assign key_done  = req.empty_key || req.last_byte;

   always_comb begin
      crc_whole_in    = crc16_byte(crc_whole_ff, req.key_byte);
      crc_tag_in      = crc_tag_ff;
      open_seen_in    = open_seen_ff;
      close_seen_in   = close_seen_ff;
      tag_nonempty_in = tag_nonempty_ff;
      if (!open_seen_ff) begin
         open_seen_in = (req.key_byte == OPEN_BRACE);
      end else if (!close_seen_ff) begin
         if (req.key_byte == CLOSE_BRACE) begin
            close_seen_in = 1'b1;
         end else begin
            crc_tag_in      = crc16_byte(crc_tag_ff, req.key_byte);
            tag_nonempty_in = 1'b1;
         end
      end
      crc_pick = (open_seen_in && close_seen_in && tag_nonempty_in) ? crc_tag_in
                                                                    : crc_whole_in;

      stage_in = stage_ff;
      if (stage_ready) begin
         stage_in.valid = 1'b0;
      end
      if (accept && key_done) begin
         stage_in.valid = 1'b1;
         stage_in.empty = req.empty_key;
         stage_in.slot  = req.empty_key ? '0 : crc_pick[SLOT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_whole_ff    <= '0;
         crc_tag_ff      <= '0;
         open_seen_ff    <= 1'b0;
         close_seen_ff   <= 1'b0;
         tag_nonempty_ff <= 1'b0;
         stage_ff.valid  <= 1'b0;
      end else begin
         if (accept) begin
            if (key_done) begin
               crc_whole_ff    <= '0;
               crc_tag_ff      <= '0;
               open_seen_ff    <= 1'b0;
               close_seen_ff   <= 1'b0;
               tag_nonempty_ff <= 1'b0;
            end else begin
               crc_whole_ff    <= crc_whole_in;
               crc_tag_ff      <= crc_tag_in;
               open_seen_ff    <= open_seen_in;
               close_seen_ff   <= close_seen_in;
               tag_nonempty_ff <= tag_nonempty_in;
            end
         end
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.empty <= stage_in.empty;
      stage_ff.slot  <= stage_in.slot;
   end

   assign stage = stage_ff;

endmodule

/* hw/rtl/cksn_node_map.sv */
// Range start registers and the slot to node lookup feeding the result register.
// Depends on cksn_pkg, cksn_rsp_if and cksn_csr_if.
module cksn_node_map import cksn_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   cksn_csr_if.sink       csr,
   input  slot_stage_type stage,
   output logic           stage_ready,
   cksn_rsp_if.source     rsp
);

   slot_type start_ff [NUM_STARTS];
   logic     rsp_valid_ff, rsp_valid_in;
   slot_type rsp_slot_ff, rsp_slot_in;
   node_type rsp_node_ff, rsp_node_in;
   node_type node_pick;

   assign csr.ready   = 1'b1;
   assign stage_ready = !rsp_valid_ff || rsp.ready;

   // Later compares win, so the highest numbered qualifying node is chosen.
   always_comb begin
      node_pick = NODE_FIRST;
      for (int k = 0; k < NUM_STARTS; k++) begin
         if (stage.slot >= start_ff[k]) begin
            node_pick = NODE_OF_START_BASE + NODE_WIDTH'(k);
         end
      end
      if (stage.empty) begin
         node_pick = NODE_FIRST;
      end

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_node_in  = rsp_node_ff;
      if (stage.valid && stage_ready) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = stage.slot;
         rsp_node_in  = node_pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STARTS; k++) begin
            start_ff[k] <= START_RESET[k];
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            case (csr_index_type'(csr.index))
               CSR_NODE2_START: start_ff[0] <= csr.data;
               CSR_NODE3_START: start_ff[1] <= csr.data;
               CSR_NODE4_START: start_ff[2] <= csr.data;
               CSR_NODE5_START: start_ff[3] <= csr.data;
               CSR_NODE6_START: start_ff[4] <= csr.data;
               default: ;
            endcase
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_slot_ff <= rsp_slot_in;
      rsp_node_ff <= rsp_node_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.slot  = rsp_slot_ff;
   assign rsp.node  = rsp_node_ff;

endmodule

/* hw/rtl/cluster_key_slot_and_node.sv */
// Top level of the cluster key slot and node block.
// Depends on cksn_pkg, the cksn interfaces, cksn_key_hash and cksn_node_map.
//
// Keys arrive one byte per transaction on req_bus; the transaction with last_byte set
// (or any transaction with empty_key set) ends the key and produces exactly one result
// transaction on rsp_bus carrying the key's hash slot and owning node. The slot is the
// low 14 bits of a CRC-16/XMODEM over the whole key, or over the hash tag between the
// first open brace and the first close brace after it when that tag is non-empty. An
// empty key gives slot 0 and node 1. The node is the highest numbered of nodes 2 to 6
// whose range start is not above the slot, or node 1 if none is. A new byte is taken
// in every cycle while backpressure does not hold it: the CRC update and brace
// tracking form one register stage, and the five range compares form a second
// stage feeding the result register. Backpressure on rsp_bus stalls both stages;
// the stages hold their data and simply stop taking new transactions.
// Range starts are written through csr_bus (index 0 is node 2 up to index 4 for
// node 6, writes to other indexes are dropped) and should only change while no key
// result is in flight.

module cluster_key_slot_and_node import cksn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   cksn_req_if.sink   req_bus,
   cksn_rsp_if.source rsp_bus,
   cksn_csr_if.sink   csr_bus
);

   // Finished keys travel from the hash stage to the lookup stage here.
   slot_stage_type slot_stage;
   logic           slot_stage_ready;

   cksn_key_hash u_key_hash (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .stage_ready (slot_stage_ready),
      .stage       (slot_stage)
   );

   cksn_node_map u_node_map (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_bus),
      .stage       (slot_stage),
      .stage_ready (slot_stage_ready),
      .rsp         (rsp_bus)
   );

endmodule

/* test/cluster_key_slot_and_node_test.sv */
// Self-checking testbench for cluster_key_slot_and_node: streams keys, rewrites range starts.
// Depends on cksn_pkg, the cksn interfaces and the block itself; needs no other files.
`timescale 1ns / 100ps

module cluster_key_slot_and_node_test;
   import cksn_pkg::*;

   // Cycles waited after the last owed result, so that the block has surely
   // gone quiet.
   localparam int DRAIN_CYCLES   = 6;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_ITEMS   = 1030;
   localparam int NUM_PHASES     = 6;
   localparam int SLOT_TOP       = (1 << SLOT_WIDTH) - 1;
   localparam int SPARE_INDEXES  = (1 << CSR_IDX_WIDTH) - 1 - NUM_STARTS;
   localparam int NUM_DIRECTED   = 21;

   // One slot and node pair as the block should report it.
   typedef struct packed {
      slot_type slot;
      node_type node;
   } key_result_type;

   // A row of the directed table. Where typed is set, the result is written in
   // by hand; otherwise it comes from the slot predictor below.
   typedef struct packed {
      logic [KEY_BYTE_WIDTH-1:0] key_byte;
      logic                      last_byte;
      logic                      empty_key;
      logic                      typed;
      slot_type                  slot;
      node_type                  node;
   } directed_row_type;

   // The directed keys. An empty key always gives slot 0 on node 1, and a key of a
   // single zero byte hashes to zero, so those results are typed in directly.
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // Empty key straight after reset, with the ignored fields at their top.
      '{8'hFF, 1'b1, 1'b1, 1'b1, 14'd0, NODE_FIRST},
      // One-byte keys at both ends of the byte range.
      '{8'h00, 1'b1, 1'b0, 1'b1, 14'd0, NODE_FIRST},
      '{8'hFF, 1'b1, 1'b0, 1'b0, 14'd0, 3'd0},
      // "{a}": the tag alone decides the slot.
      '{OPEN_BRACE,  1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{8'h61,       1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{CLOSE_BRACE, 1'b1, 1'b0, 1'b0, 14'd0, 3'd0},
      // "{}": an empty tag falls back to the whole key.
      '{OPEN_BRACE,  1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{CLOSE_BRACE, 1'b1, 1'b0, 1'b0, 14'd0, 3'd0},
      // "{b}}{": braces after the tag only feed the whole-key sum.
      '{OPEN_BRACE,  1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{8'h62,       1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{CLOSE_BRACE, 1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{CLOSE_BRACE, 1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{OPEN_BRACE,  1'b1, 1'b0, 1'b0, 14'd0, 3'd0},
      // "{z": an open brace that is never closed.
      '{OPEN_BRACE,  1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{8'h7A,       1'b1, 1'b0, 1'b0, 14'd0, 3'd0},
      // Two bytes of a key, then an empty key that throws them away.
      '{8'h41,       1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{8'h42,       1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{8'h00,       1'b0, 1'b1, 1'b1, 14'd0, NODE_FIRST},
      // "{{}": a second open brace is part of the tag.
      '{OPEN_BRACE,  1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{OPEN_BRACE,  1'b0, 1'b0, 1'b0, 14'd0, 3'd0},
      '{CLOSE_BRACE, 1'b1, 1'b0, 1'b0, 14'd0, 3'd0}
   };

   logic clock;
   logic reset;

   cksn_req_if req_bus ();
   cksn_rsp_if rsp_bus ();
   cksn_csr_if csr_bus ();

   cluster_key_slot_and_node DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Mirror of the block's key state and range registers.
   crc_type  crc_full;
   crc_type  crc_hashtag;
   logic     brace_open;
   logic     brace_close;
   logic     tag_has_bytes;
   slot_type range_first [NUM_STARTS];
   slot_type new_starts [NUM_STARTS];

   // Results still owed by the block, oldest first.
   key_result_type pending_results [$];

   // When set, neither side inserts idle cycles, so transactions go back to back.
   bit steady_flow;

   int items_sent;
   int results_checked;
   int tag_results;
   int empty_results;
   int csr_writes;
   int mismatch_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // CRC-16/XMODEM, one key bit at a time, most significant bit first.
   function automatic crc_type crc_shift_in(crc_type crc, logic [KEY_BYTE_WIDTH-1:0] kb);
      crc_type acc;
      logic    feedback;
      acc = crc;
      for (int i = KEY_BYTE_WIDTH - 1; i >= 0; i--) begin
         feedback = acc[CRC_WIDTH-1] ^ kb[i];
         acc = {acc[CRC_WIDTH-2:0], 1'b0};
         if (feedback) begin
            acc = acc ^ CRC_POLY;
         end
      end
      return acc;
   endfunction

   function automatic void forget_key();
      crc_full      = '0;
      crc_hashtag   = '0;
      brace_open    = 1'b0;
      brace_close   = 1'b0;
      tag_has_bytes = 1'b0;
   endfunction

   // Advances the mirrored key state by one transaction. Returns 1 when the key
   // ends here, with the slot and node the block has to report.
   function automatic bit predict_key_slot(input logic [KEY_BYTE_WIDTH-1:0] kb,
                                           input logic lb, input logic ek,
                                           output slot_type slot, output node_type node,
                                           output bit from_tag);
      bit found;
      slot     = '0;
      node     = NODE_FIRST;
      from_tag = 1'b0;
      found    = 1'b0;
      if (ek) begin
         forget_key();
         return 1'b1;
      end
      crc_full = crc_shift_in(crc_full, kb);
      if (!brace_open) begin
         brace_open = (kb == OPEN_BRACE);
      end else if (!brace_close) begin
         if (kb == CLOSE_BRACE) begin
            brace_close = 1'b1;
         end else begin
            crc_hashtag   = crc_shift_in(crc_hashtag, kb);
            tag_has_bytes = 1'b1;
         end
      end
      if (!lb) begin
         return 1'b0;
      end
      from_tag = brace_open && brace_close && tag_has_bytes;
      slot = from_tag ? crc_hashtag[SLOT_WIDTH-1:0] : crc_full[SLOT_WIDTH-1:0];
      // The highest numbered node whose start is not above the slot wins, even
      // when the starts are out of order.
      for (int k = NUM_STARTS - 1; k >= 0; k--) begin
         if (!found && slot >= range_first[k]) begin
            node  = NODE_OF_START_BASE + node_type'(k);
            found = 1'b1;
         end
      end
      forget_key();
      return 1'b1;
   endfunction

   // Drives one key transaction and, once it is accepted, queues what it should produce.
   task automatic send_key_item(input logic [KEY_BYTE_WIDTH-1:0] kb, input logic lb,
                                input logic ek, input logic typed,
                                input slot_type typed_slot, input node_type typed_node);
      int             gap;
      key_result_type outcome;
      slot_type       slot;
      node_type       node;
      bit             from_tag;
      gap = steady_flow ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.key_byte  <= kb;
      req_bus.last_byte <= lb;
      req_bus.empty_key <= ek;
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      items_sent++;
      if (predict_key_slot(kb, lb, ek, slot, node, from_tag)) begin
         outcome.slot = typed ? typed_slot : slot;
         outcome.node = typed ? typed_node : node;
         pending_results.push_back(outcome);
         tag_results   += from_tag;
         empty_results += ek;
      end
   endtask

   // Braces turn up often enough that tags of every shape appear.
   function automatic logic [KEY_BYTE_WIDTH-1:0] pick_key_byte();
      case ($urandom_range(0, 7))
         0: begin
            return OPEN_BRACE;
         end
         1: begin
            return CLOSE_BRACE;
         end
         default: begin
            return KEY_BYTE_WIDTH'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // Sends one random key. Most keys are complete, many of them shaped around a
   // hash tag; the rest are empty keys, alone or cutting a key short.
   task automatic send_random_key();
      logic [KEY_BYTE_WIDTH-1:0] key_bytes [$];
      int shape;
      int len;
      shape = $urandom_range(0, 9);
      if (shape == 1) begin
         repeat ($urandom_range(1, 4)) key_bytes.push_back(pick_key_byte());
      end else if (shape >= 2 && shape <= 5) begin
         repeat ($urandom_range(0, 3)) key_bytes.push_back(pick_key_byte());
         key_bytes.push_back(OPEN_BRACE);
         repeat ($urandom_range(0, 4)) key_bytes.push_back(KEY_BYTE_WIDTH'($urandom_range(0, 255)));
         key_bytes.push_back(CLOSE_BRACE);
         repeat ($urandom_range(0, 3)) key_bytes.push_back(pick_key_byte());
      end else if (shape >= 6) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
         repeat (len) key_bytes.push_back(pick_key_byte());
      end
      foreach (key_bytes[i]) begin
         send_key_item(key_bytes[i], (shape > 1) && (i == key_bytes.size() - 1), 1'b0,
                       1'b0, '0, '0);
      end
      if (shape <= 1) begin
         send_key_item(KEY_BYTE_WIDTH'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'b1, 1'b0, '0, '0);
      end
   endtask

   // Writes new_starts into the five range registers, then one write to a random
   // index past them, which the block has to drop.
   task automatic load_range_starts();
      csr_index_type reg_idx;
      reg_idx = reg_idx.first();
      for (int k = 0; k < NUM_STARTS; k++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= reg_idx;
         csr_bus.data  <= new_starts[k];
         do begin
            @(posedge clock);
         end while (csr_bus.ready !== 1'b1);
         range_first[k] = new_starts[k];
         csr_writes++;
         reg_idx = reg_idx.next();
      end
      csr_bus.index <= CSR_IDX_WIDTH'(NUM_STARTS + $urandom_range(0, SPARE_INDEXES));
      csr_bus.data  <= SLOT_WIDTH'($urandom_range(0, SLOT_TOP));
      do begin
         @(posedge clock);
      end while (csr_bus.ready !== 1'b1);
      csr_writes++;
      csr_bus.valid <= 1'b0;
   endtask

   // Waits until every owed result has arrived and the pipeline has had time to empty.
   task automatic drain_results();
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: stalls a random number of cycles before each result, then takes
   // it and compares it with the oldest expectation.
   initial begin : result_checker
      key_result_type want;
      int             stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 3);
         repeat (stall) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (rsp_bus.valid !== 1'b1);
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, got slot %0d node %0d",
                     $time, rsp_bus.slot, rsp_bus.node);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_bus.slot !== want.slot) begin
               $display("%0t: slot mismatch, expected %0d, got %0d",
                        $time, want.slot, rsp_bus.slot);
               mismatch_count++;
            end
            if (rsp_bus.node !== want.node) begin
               $display("%0t: node mismatch, expected %0d, got %0d",
                        $time, want.node, rsp_bus.node);
               mismatch_count++;
            end
         end
      end
   end

   // A hung handshake or a lost result ends the run here.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("cluster_key_slot_and_node_test: FAIL");
      $finish;
   end

   initial begin : stimulus
      int phase_end;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.key_byte  = '0;
      req_bus.last_byte = 1'b0;
      req_bus.empty_key = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      steady_flow       = 1'b0;
      items_sent        = 0;
      results_checked   = 0;
      tag_results       = 0;
      empty_results     = 0;
      csr_writes        = 0;
      mismatch_count    = 0;
      forget_key();
      for (int k = 0; k < NUM_STARTS; k++) begin
         range_first[k] = START_RESET[k];
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed keys run against the reset range starts.
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         send_key_item(DIRECTED_ROWS[r].key_byte, DIRECTED_ROWS[r].last_byte,
                       DIRECTED_ROWS[r].empty_key, DIRECTED_ROWS[r].typed,
                       DIRECTED_ROWS[r].slot, DIRECTED_ROWS[r].node);
      end
      req_bus.valid <= 1'b0;

      // Each phase loads a new set of range starts while the block is idle, then
      // streams random keys. The sets go from every start at zero (everything on
      // node 6) and every start at the top (almost everything on node 1) through
      // random, descending and ascending sets to the reset values again.
      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         drain_results();
         for (int k = 0; k < NUM_STARTS; k++) begin
            case (phase)
               1: begin
                  new_starts[k] = '0;
               end
               2: begin
                  new_starts[k] = '1;
               end
               3: begin
                  new_starts[k] = SLOT_WIDTH'($urandom_range(0, SLOT_TOP));
               end
               4: begin
                  new_starts[k] = SLOT_WIDTH'(SLOT_TOP - k * 3000 - $urandom_range(0, 999));
               end
               5: begin
                  new_starts[k] = SLOT_WIDTH'((k + 1) * 2700 + $urandom_range(0, 500));
               end
               default: begin
                  new_starts[k] = START_RESET[k];
               end
            endcase
         end
         load_range_starts();
         steady_flow = (phase == 2) || (phase == 5);
         phase_end = items_sent + RANDOM_ITEMS / NUM_PHASES;
         while (items_sent < phase_end) begin
            send_random_key();
         end
         req_bus.valid <= 1'b0;
      end
      drain_results();

      $display("Sent %0d key transactions under %0d range start settings (%0d register writes).",
               items_sent, NUM_PHASES + 1, csr_writes);
      $display("Checked %0d results: %0d chosen by hash tag, %0d empty keys, %0d mismatches.",
               results_checked, tag_results, empty_results, mismatch_count);
      if (mismatch_count == 0) begin
         $display("cluster_key_slot_and_node_test: PASS");
      end else begin
         $display("cluster_key_slot_and_node_test: FAIL");
      end
      $finish;
   end

endmodule
